// File: rtl/core/mp2a_pkg.sv
`default_nettype none
package mp2a_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_WINDOW  = 8;
	localparam int MAX_STRIDE  = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int IDX_BITS    = 29;
	localparam int FLAT_BITS   = 28;
	localparam int DIM_BITS    = 9;
	localparam int POS_BITS    = 8;
	localparam int SIZE_BITS   = 4;
	localparam int PAD_BITS    = 3;
	localparam int OFF_BITS    = 2;
	localparam int SPAN_BITS   = 3;
	localparam int STORE_COLS  = MAX_WIDTH + 8;
	localparam int STORE_DEPTH = MAX_WINDOW * STORE_COLS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int ENTRY_BITS  = SAMPLE_BITS + IDX_BITS;
	localparam int PADDR_BITS  = 5;
	localparam int PDATA_BITS  = 32;

	typedef enum logic [2:0] {
		REG_IN_WIDTH    = 3'd0,
		REG_IN_HEIGHT   = 3'd1,
		REG_WINDOW_SIZE = 3'd2,
		REG_STRIDE      = 3'd3,
		REG_PADDING     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CALC_START,
		ST_CALC_WAIT,
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_UPDATE,
		ST_ADVANCE
	} state_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [DIM_BITS-1:0]  w;
		logic [DIM_BITS-1:0]  h;
		logic [SIZE_BITS-1:0] sz;
		logic [SIZE_BITS-1:0] s;
		logic [PAD_BITS-1:0]  pad;
		logic [OFF_BITS-1:0]  off;
	} cfg_t;

	typedef struct packed {
		logic dim_start;
		logic restart;
		logic accept;
		logic setup;
		logic rd;
		logic upd;
		logic adv;
	} cmd_t;

	typedef struct packed {
		logic dim_done;
		logic has_cells;
		logic more_cells;
		logic emit;
		logic out_free;
	} sts_t;

	// window offsets that cover one position along one axis
	typedef struct packed {
		logic                 ok;
		logic [SPAN_BITS-1:0] mstart;
		logic [SPAN_BITS-1:0] mend;
	} span_t;

endpackage
`default_nettype wire

// File: rtl/core/mp2a_ram.sv
`default_nettype none
module mp2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/mp2a_dim.sv
`default_nettype none
module mp2a_dim (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire mp2a_pkg::cfg_t                cfg,
	output logic                               done,
	output logic [mp2a_pkg::DIM_BITS-1:0]      out_w,
	output logic [mp2a_pkg::DIM_BITS-1:0]      out_h
);
	import mp2a_pkg::*;

	logic                 busy_q;
	logic [3:0]           cnt_q;
	logic [DIM_BITS-1:0]  xw_q, xh_q;
	logic [2:0]           remw_q, remh_q;
	logic                 geqw_q, geqh_q, altw_q, alth_q;
	logic [DIM_BITS-1:0]  aw, ah;
	logic [SIZE_BITS:0]   tw, th;
	logic                 gew, geh;

	assign aw = cfg.w + DIM_BITS'(cfg.pad);
	assign ah = cfg.h + DIM_BITS'(cfg.pad);

	// one restoring division step per cycle, quotient shifts in from the bottom
	assign tw  = {1'b0, remw_q, xw_q[DIM_BITS-1]};
	assign th  = {1'b0, remh_q, xh_q[DIM_BITS-1]};
	assign gew = tw >= {1'b0, cfg.s};
	assign geh = th >= {1'b0, cfg.s};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(DIM_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			geqw_q <= aw >= DIM_BITS'(cfg.sz);
			geqh_q <= ah >= DIM_BITS'(cfg.sz);
			xw_q   <= aw - DIM_BITS'(cfg.sz);
			xh_q   <= ah - DIM_BITS'(cfg.sz);
			altw_q <= (DIM_BITS'(cfg.sz) - aw) < DIM_BITS'(cfg.s);
			alth_q <= (DIM_BITS'(cfg.sz) - ah) < DIM_BITS'(cfg.s);
			remw_q <= '0;
			remh_q <= '0;
		end else if (busy_q) begin
			xw_q   <= {xw_q[DIM_BITS-2:0], gew};
			xh_q   <= {xh_q[DIM_BITS-2:0], geh};
			remw_q <= gew ? 3'(tw - {1'b0, cfg.s}) : 3'(tw);
			remh_q <= geh ? 3'(th - {1'b0, cfg.s}) : 3'(th);
		end
	end

	assign done  = !busy_q;
	assign out_w = geqw_q ? xw_q + DIM_BITS'(1) : DIM_BITS'(altw_q);
	assign out_h = geqh_q ? xh_q + DIM_BITS'(1) : DIM_BITS'(alth_q);
endmodule
`default_nettype wire

// File: rtl/core/mp2a_ctrl.sv
`default_nettype none
module mp2a_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mp2a_pkg::sts_t sts,
	output mp2a_pkg::cmd_t      cmd
);
	import mp2a_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CALC_START;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CALC_START: state_nx = ST_CALC_WAIT;
			ST_CALC_WAIT: begin
				if (sts.dim_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_SETUP;
			end
			ST_SETUP: state_nx = sts.has_cells ? ST_READ : ST_ADVANCE;
			ST_READ: state_nx = ST_UPDATE;
			ST_UPDATE: begin
				if (!sts.emit || sts.out_free) begin
					state_nx = sts.more_cells ? ST_READ : ST_ADVANCE;
				end
			end
			ST_ADVANCE: state_nx = ST_IDLE;
			default: state_nx = ST_CALC_START;
		endcase
		if (cfg_wr) state_nx = ST_CALC_START;
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CALC_START: cmd.dim_start = 1'b1;
			ST_CALC_WAIT: cmd.restart = sts.dim_done;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_READ: cmd.rd = 1'b1;
			ST_UPDATE: cmd.upd = !sts.emit || sts.out_free;
			ST_ADVANCE: cmd.adv = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/core/mp2a_dp.sv
`default_nettype none
module mp2a_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mp2a_pkg::cfg_t                      cfg,
	input  wire mp2a_pkg::cmd_t                      cmd,
	output mp2a_pkg::sts_t                           sts,
	input  wire logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [mp2a_pkg::SAMPLE_BITS-1:0]  max_value,
	output logic signed [mp2a_pkg::IDX_BITS-1:0]     source_index,
	output logic [mp2a_pkg::DIM_BITS-1:0]            out_row,
	output logic [mp2a_pkg::DIM_BITS-1:0]            out_col,
	output logic                                     last_of_run
);
	import mp2a_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] VMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// first window and phase for position 0 along an axis
	function automatic logic [DIM_BITS+2:0] start_phase(input logic [OFF_BITS-1:0] off,
			input logic [SIZE_BITS-1:0] s);
		logic [DIM_BITS-1:0] q;
		logic [2:0]          r;
		begin
			q = '0;
			r = 3'(off);
			if (s == 4'd1) begin
				q = DIM_BITS'(off);
				r = '0;
			end else if (s == 4'd2) begin
				q = DIM_BITS'(off[1]);
				r = 3'(off[0]);
			end else if (s == 4'd3 && off == 2'd3) begin
				q = DIM_BITS'(1);
				r = '0;
			end
			return {q, r};
		end
	endfunction

	// windows covering a position: hi = q, distances rem + m*s for m = 0..
	function automatic span_t span_of(input logic [DIM_BITS-1:0] q, input logic [2:0] rem,
			input logic [DIM_BITS-1:0] cnt, input logic [SIZE_BITS-1:0] s,
			input logic [SIZE_BITS-1:0] sz);
		span_t               sp;
		logic [3:0]          n;
		logic [DIM_BITS:0]   nr;
		logic [DIM_BITS-1:0] mend;
		begin
			n = '0;
			for (int m = 0; m < MAX_WINDOW; m++) begin
				if (7'(rem) + 7'(m) * 7'(s) <= 7'(sz) - 7'd1) n = n + 4'd1;
			end
			nr   = ({6'b0, n} > {1'b0, q} + 10'd1) ? {1'b0, q} + 10'd1 : {6'b0, n};
			mend = (q > cnt - DIM_BITS'(1)) ? q - (cnt - DIM_BITS'(1)) : '0;
			sp.ok     = (n != 4'd0) && (cnt != '0) && (nr - 10'd1 >= {1'b0, mend});
			sp.mstart = SPAN_BITS'(nr - 10'd1);
			sp.mend   = SPAN_BITS'(mend);
			return sp;
		end
	endfunction

	logic [POS_BITS-1:0]    c_q, r_q;
	logic [DIM_BITS-1:0]    qc_q, qr_q;
	logic [2:0]             rc_q, rr_q;
	logic [FLAT_BITS-1:0]   flat_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [SPAN_BITS-1:0]   mi_q, mj_q, mj_start_q, mi_end_q, mj_end_q;
	logic                   dim_done;
	logic [DIM_BITS-1:0]    out_w, out_h;
	logic [DIM_BITS+2:0]    ph0;
	span_t                  span_r, span_c;
	logic                   last_col, last_row;
	logic [6:0]             d_r, d_c, szm1;
	logic [DIM_BITS-1:0]    cell_i, cell_j;
	logic                   row_first, col_first, row_emit, col_emit;
	logic [STORE_AW-1:0]    addr;
	logic [ENTRY_BITS-1:0]  rd_entry, wr_entry;
	logic signed [SAMPLE_BITS-1:0] base_val, new_val;
	logic signed [IDX_BITS-1:0]    base_idx, new_idx;
	logic                   out_valid_q;

	mp2a_dim u_dim (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.dim_start),
		.cfg    (cfg),
		.done   (dim_done),
		.out_w  (out_w),
		.out_h  (out_h)
	);

	assign ph0      = start_phase(cfg.off, cfg.s);
	assign span_r   = span_of(qr_q, rr_q, out_h, cfg.s, cfg.sz);
	assign span_c   = span_of(qc_q, rc_q, out_w, cfg.s, cfg.sz);
	assign last_col = {1'b0, c_q} == cfg.w - DIM_BITS'(1);
	assign last_row = {1'b0, r_q} == cfg.h - DIM_BITS'(1);

	// current cell
	assign szm1      = 7'(cfg.sz) - 7'd1;
	assign d_r       = 7'(rr_q) + 7'(mi_q) * 7'(cfg.s);
	assign d_c       = 7'(rc_q) + 7'(mj_q) * 7'(cfg.s);
	assign cell_i    = qr_q - DIM_BITS'(mi_q);
	assign cell_j    = qc_q - DIM_BITS'(mj_q);
	assign row_first = (r_q == '0) || (d_r == '0);
	assign col_first = (c_q == '0) || (d_c == '0);
	assign row_emit  = last_row || (d_r == szm1);
	assign col_emit  = last_col || (d_c == szm1);
	assign addr      = STORE_AW'(32'(cell_i[2:0]) * STORE_COLS + 32'(cell_j));

	mp2a_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (addr),
		.wdata (wr_entry),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (rd_entry)
	);

	always_comb begin
		base_val = row_first && col_first ? VMIN : rd_entry[ENTRY_BITS-1:IDX_BITS];
		base_idx = row_first && col_first ? '1 : rd_entry[IDX_BITS-1:0];
		new_val  = base_val;
		new_idx  = base_idx;
		if (sample_q > base_val) begin
			new_val = sample_q;
			new_idx = IDX_BITS'(flat_q);
		end
		wr_entry = {new_val, new_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q         <= '0;
			r_q         <= '0;
			flat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				c_q <= '0;
				r_q <= '0;
			end else if (cmd.adv) begin
				flat_q <= flat_q + FLAT_BITS'(1);
				if (last_col) begin
					c_q <= '0;
					r_q <= last_row ? '0 : r_q + POS_BITS'(1);
				end else begin
					c_q <= c_q + POS_BITS'(1);
				end
			end
			if (cmd.upd && row_emit && col_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			{qc_q, rc_q} <= ph0;
			{qr_q, rr_q} <= ph0;
		end else if (cmd.adv) begin
			if (last_col) begin
				{qc_q, rc_q} <= ph0;
				if (last_row) begin
					{qr_q, rr_q} <= ph0;
				end else if ({1'b0, rr_q} + 4'd1 == cfg.s) begin
					rr_q <= '0;
					qr_q <= qr_q + DIM_BITS'(1);
				end else begin
					rr_q <= rr_q + 3'd1;
				end
			end else if ({1'b0, rc_q} + 4'd1 == cfg.s) begin
				rc_q <= '0;
				qc_q <= qc_q + DIM_BITS'(1);
			end else begin
				rc_q <= rc_q + 3'd1;
			end
		end
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.setup) begin
			mi_q       <= span_r.mstart;
			mi_end_q   <= span_r.mend;
			mj_q       <= span_c.mstart;
			mj_start_q <= span_c.mstart;
			mj_end_q   <= span_c.mend;
		end else if (cmd.upd) begin
			if (mj_q != mj_end_q) begin
				mj_q <= mj_q - SPAN_BITS'(1);
			end else begin
				mj_q <= mj_start_q;
				mi_q <= mi_q - SPAN_BITS'(1);
			end
		end
		if (cmd.upd && row_emit && col_emit) begin
			max_value    <= new_val;
			source_index <= new_idx;
			out_row      <= cell_i;
			out_col      <= cell_j;
			last_of_run  <= (!last_row || mi_q == mi_end_q) && (!last_col || mj_q == mj_end_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.dim_done   = dim_done;
	assign sts.has_cells  = span_r.ok && span_c.ok;
	assign sts.more_cells = (mj_q != mj_end_q) || (mi_q != mi_end_q);
	assign sts.emit       = row_emit && col_emit;
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// File: rtl/core/max_pool_2d_argmax.sv
// per sample: setup, a read and update of the partial store per covering window, advance
// covering windows per sample k <= ceil(window_size/stride)^2; the next sample word is
//   taken only after advance, and an emitting update waits while a result word is held
// reset: config registers return to 16x16, window 2, stride 2, no padding; counters clear
//   and the output size is recomputed before the first sample word is taken
// every config write restarts the plane and recomputes the output size the same way
`default_nettype none
module max_pool_2d_argmax (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mp2a_pkg::PADDR_BITS-1:0]     paddr,
	input  wire logic [mp2a_pkg::PDATA_BITS-1:0]     pwdata,
	output logic [mp2a_pkg::PDATA_BITS-1:0]          prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [mp2a_pkg::SAMPLE_BITS-1:0]  max_value,
	output logic signed [mp2a_pkg::IDX_BITS-1:0]     source_index,
	output logic [mp2a_pkg::DIM_BITS-1:0]            out_row,
	output logic [mp2a_pkg::DIM_BITS-1:0]            out_col,
	output logic                                     last_of_run
);
	import mp2a_pkg::*;

	// raw register values, clamped below
	logic [DIM_BITS-1:0]  in_width_q, in_height_q;
	logic [SIZE_BITS-1:0] window_size_q, stride_q;
	logic [PAD_BITS-1:0]  padding_q;
	reg_idx_t             reg_idx;
	logic                 wr_hit, cfg_wr;
	cfg_t                 cfg;
	logic [SIZE_BITS-1:0] pad_lim;
	cmd_t                 cmd;
	sts_t                 sts;

	assign reg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);
	assign wr_hit  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// only listed registers take a write; the rest are dropped
	always_comb begin
		cfg_wr = 1'b0;
		prdata = '0;
		case (reg_idx)
			REG_IN_WIDTH: begin
				cfg_wr = wr_hit;
				prdata = PDATA_BITS'(in_width_q);
			end
			REG_IN_HEIGHT: begin
				cfg_wr = wr_hit;
				prdata = PDATA_BITS'(in_height_q);
			end
			REG_WINDOW_SIZE: begin
				cfg_wr = wr_hit;
				prdata = PDATA_BITS'(window_size_q);
			end
			REG_STRIDE: begin
				cfg_wr = wr_hit;
				prdata = PDATA_BITS'(stride_q);
			end
			REG_PADDING: begin
				cfg_wr = wr_hit;
				prdata = PDATA_BITS'(padding_q);
			end
			default: begin
				cfg_wr = 1'b0;
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q    <= DIM_BITS'(16);
			in_height_q   <= DIM_BITS'(16);
			window_size_q <= SIZE_BITS'(2);
			stride_q      <= SIZE_BITS'(2);
			padding_q     <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IN_WIDTH:    in_width_q    <= pwdata[DIM_BITS-1:0];
				REG_IN_HEIGHT:   in_height_q   <= pwdata[DIM_BITS-1:0];
				REG_WINDOW_SIZE: window_size_q <= pwdata[SIZE_BITS-1:0];
				REG_STRIDE:      stride_q      <= pwdata[SIZE_BITS-1:0];
				REG_PADDING:     padding_q     <= pwdata[PAD_BITS-1:0];
				default:         padding_q     <= padding_q;
			endcase
		end
	end

	// clamp into the supported ranges; padding saturates at window_size-1
	always_comb begin
		cfg.w = (in_width_q == '0) ? DIM_BITS'(1) :
			(in_width_q > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : in_width_q;
		cfg.h = (in_height_q == '0) ? DIM_BITS'(1) :
			(in_height_q > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : in_height_q;
		cfg.sz = (window_size_q == '0) ? SIZE_BITS'(1) :
			(window_size_q > SIZE_BITS'(MAX_WINDOW)) ? SIZE_BITS'(MAX_WINDOW) : window_size_q;
		cfg.s = (stride_q == '0) ? SIZE_BITS'(1) :
			(stride_q > SIZE_BITS'(MAX_STRIDE)) ? SIZE_BITS'(MAX_STRIDE) : stride_q;
		pad_lim = cfg.sz - SIZE_BITS'(1);
		cfg.pad = ({1'b0, padding_q} > pad_lim) ? PAD_BITS'(pad_lim) : padding_q;
		cfg.off = cfg.pad[PAD_BITS-1:1];
	end

	// sequencer: size calc, per-sample setup, read/update per covered window, advance
	mp2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// position counters, partial max store and the result word register
	mp2a_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_value    (max_value),
		.source_index (source_index),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run)
	);
endmodule
`default_nettype wire
